### rtl/qtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qtg_pkg;

   // Width of the tick down-counter that times each half period or silent slot.
   localparam int unsigned COUNT_WIDTH = 16;

   localparam int unsigned HALF_WIDTH = 16;
   localparam int unsigned LEN_WIDTH  = 16;
   localparam int unsigned CFG_WIDTH  = 16;

   localparam logic [CFG_WIDTH-1:0] MIN_HALF_RESET = 16'd1200;
   localparam logic [CFG_WIDTH-1:0] SILENT_RESET   = 16'd12000;

   // Byte address layout of the register file.
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic CSR_SEL_MIN_HALF = 1'b0;
   localparam logic CSR_SEL_SILENT   = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_PLAY  = 2'd1,
      OP_QUEUE = 2'd2,
      OP_STOP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_QUEUED = 2'd1,
      MODE_NOW    = 2'd2
   } mode_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] min_half_period;
      logic [CFG_WIDTH-1:0] silent_slot;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            op;
      logic [HALF_WIDTH-1:0] tone_half_period;
      logic [LEN_WIDTH-1:0]  tone_length;
   } item_type;

   typedef struct packed {
      logic pin_level;
      logic playing;
      logic next_pending;
   } result_type;

   // Fits a 16-bit distance to the counter width: truncates or zero-extends.
   function automatic logic [COUNT_WIDTH-1:0] fit_count(input logic [HALF_WIDTH-1:0] value);
      logic [31:0] wide;
      wide = 32'(value);
      return wide[COUNT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/qtg_core.sv
`timescale 1ns / 1ps
`default_nettype none

module qtg_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire qtg_pkg::item_type  item,
   input  wire qtg_pkg::cfg_type   cfg,
   output qtg_pkg::result_type     result
);
   import qtg_pkg::*;

   logic                   running_ff,   running_in;
   logic [HALF_WIDTH-1:0]  active_ff,    active_in;
   logic [LEN_WIDTH-1:0]   remain_ff,    remain_in;
   mode_type               mode_ff,      mode_in;
   logic [HALF_WIDTH-1:0]  pend_half_ff, pend_half_in;
   logic [LEN_WIDTH-1:0]   pend_len_ff,  pend_len_in;
   logic [COUNT_WIDTH-1:0] ticks_ff,     ticks_in;
   logic                   clears_ff,    clears_in;
   logic                   pin_ff,       pin_in;

   logic [COUNT_WIDTH-1:0] ticks_dec;
   logic [LEN_WIDTH-1:0]   remain_dec;
   logic                   take_pending;
   logic [HALF_WIDTH-1:0]  half_adj;

   assign ticks_dec  = ticks_ff - COUNT_WIDTH'(1);
   assign remain_dec = (remain_ff != '0) ? remain_ff - LEN_WIDTH'(1) : remain_ff;
   assign take_pending = (mode_ff == MODE_NOW) ||
                         ((remain_dec == '0) && (mode_ff != MODE_NONE));
   assign half_adj = ((item.tone_half_period != '0) &&
                      (item.tone_half_period < cfg.min_half_period)) ?
                     cfg.min_half_period : item.tone_half_period;

   always_comb begin
      running_in   = running_ff;
      active_in    = active_ff;
      remain_in    = remain_ff;
      mode_in      = mode_ff;
      pend_half_in = pend_half_ff;
      pend_len_in  = pend_len_ff;
      ticks_in     = ticks_ff;
      clears_in    = clears_ff;
      pin_in       = pin_ff;
      case (op_type'(item.op))
         OP_TICK: begin
            if (running_ff) begin
               ticks_in = ticks_dec;
               if (ticks_dec == '0) begin
                  if (clears_ff) begin
                     // End of a period: count it down and pick the next tone.
                     pin_in = 1'b0;
                     remain_in = remain_dec;
                     if (take_pending) begin
                        mode_in   = MODE_NONE;
                        active_in = pend_half_ff;
                        remain_in = pend_len_ff;
                     end
                     if (remain_in == '0) begin
                        running_in = 1'b0;
                        clears_in  = 1'b1;
                     end else if (active_in == '0) begin
                        ticks_in = fit_count(cfg.silent_slot);
                     end else begin
                        clears_in = 1'b0;
                        ticks_in  = fit_count(active_in);
                     end
                  end else begin
                     pin_in    = 1'b1;
                     clears_in = 1'b1;
                     ticks_in  = fit_count(active_ff);
                  end
               end
            end
         end
         OP_PLAY, OP_QUEUE: begin
            pend_half_in = half_adj;
            pend_len_in  = item.tone_length;
            mode_in      = (op_type'(item.op) == OP_PLAY) ? MODE_NOW : MODE_QUEUED;
            if (!running_ff) begin
               running_in = 1'b1;
               active_in  = '0;
               remain_in  = '0;
               ticks_in   = COUNT_WIDTH'(1);
               clears_in  = 1'b1;
               pin_in     = 1'b0;
            end
         end
         OP_STOP: begin
            if (running_ff) begin
               running_in = 1'b0;
               pin_in     = 1'b0;
               mode_in    = MODE_NONE;
               clears_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         active_ff    <= '0;
         remain_ff    <= '0;
         mode_ff      <= MODE_NONE;
         pend_half_ff <= '0;
         pend_len_ff  <= '0;
         ticks_ff     <= '0;
         clears_ff    <= 1'b1;
         pin_ff       <= 1'b0;
      end else if (item_valid) begin
         running_ff   <= running_in;
         active_ff    <= active_in;
         remain_ff    <= remain_in;
         mode_ff      <= mode_in;
         pend_half_ff <= pend_half_in;
         pend_len_ff  <= pend_len_in;
         ticks_ff     <= ticks_in;
         clears_ff    <= clears_in;
         pin_ff       <= pin_in;
      end
   end

   // The result of an item is the state it leaves behind.
   assign result.pin_level    = pin_in;
   assign result.playing      = running_in;
   assign result.next_pending = (mode_in != MODE_NONE);

endmodule

`default_nettype wire

### rtl/queued_tone_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Square-wave buzzer driver with a one-tone queue.
// The req_ stream carries one word per timer tick or command (play now, queue
// next, stop); the rsp_ stream returns exactly one word per request word with
// the pin level, the playing flag and the queued flag after that request.
// The result of an accepted word is registered in the result register, or in
// the skid register while that one is full and not taken. Throughput is one
// word per cycle while rsp_tready stays high; all the work for a word is a
// single pass through the tone state update in the core, after the handshake.
// A two-entry output stage (result register plus skid register) decouples the
// sides: req_tready depends only on registered state, so a new word is taken
// while one result waits. When the receiver stalls, at most two results are
// held and req_tready falls until one has been taken; nothing is dropped.
// The csr_ port holds min_half_period (address 0) and silent_slot (address 4);
// write them only while the block is idle.
// Synchronous reset stops the generator, empties the queue and the output
// stage, and restores the registers to 1200 and 12000.
module queued_tone_generator (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] op, [17:2] tone_half_period, [33:18] tone_length, [39:34] zero
   input  wire logic [39:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] pin_level, [1] playing, [2] next_pending, [7:3] zero
   output logic [7:0]       rsp_tdata,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [qtg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import qtg_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item;
   result_type result;
   logic       accept_in;
   logic       take_out;
   logic       csr_write;

   logic       main_valid_ff, main_valid_in;
   result_type main_ff,       main_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff,       skid_in;

   // Configuration registers. Only the word-select bit of the address is
   // decoded, so each register answers at every byte of its word.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_SEL_MIN_HALF) begin
            cfg_in.min_half_period = csr_pwdata[CFG_WIDTH-1:0];
         end else begin
            cfg_in.silent_slot = csr_pwdata[CFG_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_half_period <= MIN_HALF_RESET;
         cfg_ff.silent_slot     <= SILENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_SEL_SILENT) ?
                       32'(cfg_ff.silent_slot) : 32'(cfg_ff.min_half_period);

   // Request side: unpack the word and run it through the tone state.
   assign req_tready = !skid_valid_ff;
   assign accept_in  = req_tvalid && req_tready;

   assign item.op               = req_tdata[1:0];
   assign item.tone_half_period = req_tdata[17:2];
   assign item.tone_length      = req_tdata[33:18];

   qtg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept_in),
      .item       (item),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // Output stage. The skid register only fills when a word arrives while the
   // result register is full and not being taken; it drains into the result
   // register before any new word is accepted.
   assign take_out = main_valid_ff && rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || take_out) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = accept_in;
            main_in       = result;
         end
      end else if (accept_in) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {5'b0, main_ff.next_pending, main_ff.playing, main_ff.pin_level};

endmodule

`default_nettype wire
